// ----- rtl/mlfs_pkg.sv -----
// Package for the multi-slot LED flash scheduler.
// Holds the table sizes, the request codes, the slot and result types and the
// color helpers. It depends on nothing else.
package mlfs_pkg;

   localparam int SLOT_COUNT   = 64;
   localparam int CHANNEL_BITS = 8;
   localparam int MAX_RESULTS  = 64;

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int COLOR_W    = 4 * CHANNEL_BITS;

   // Request codes.
   localparam logic [1:0] REQ_TICK        = 2'd0;
   localparam logic [1:0] REQ_ENABLE      = 2'd1;
   localparam logic [1:0] REQ_DISABLE     = 2'd2;
   localparam logic [1:0] REQ_DISABLE_ALL = 2'd3;

   // One slot of the table as it is kept in the slot memory.
   typedef struct packed {
      logic [15:0]        period;
      logic [15:0]        remaining;
      logic               lit;
      logic [COLOR_W-1:0] color;
      logic [7:0]         led;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // One result item without its commit flag.
   typedef struct packed {
      logic       write_valid;
      logic [7:0] led;
      logic [7:0] brightness;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } result_type;

   // What the slot update decides for the slot under work.
   typedef struct packed {
      logic           mem_write;
      slot_entry_type wr_entry;
      logic           en_next;
      logic           claim;
      logic           emit;
      result_type     res;
   } slot_act_type;

   // Keeps the low CHANNEL_BITS bits of an 8-bit input channel.
   function automatic logic [CHANNEL_BITS-1:0] chan_in(input logic [7:0] value);
      logic [15:0] wide;
      wide = {8'd0, value};
      return wide[CHANNEL_BITS-1:0];
   endfunction

   // Keeps the low 8 bits of a stored channel.
   function automatic logic [7:0] chan_out(input logic [CHANNEL_BITS-1:0] value);
      logic [15:0] wide;
      wide = 16'(value);
      return wide[7:0];
   endfunction

endpackage

// ----- rtl/mlfs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the slot table of the flash scheduler; it depends on nothing else.
module mlfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mlfs_slot_alu.sv -----
// Per-slot update of the flash scheduler: decides the new slot contents, the
// enable bit and the result item for the slot read from memory. Uses mlfs_pkg.
module mlfs_slot_alu (
   input  logic [1:0]                   op,
   input  mlfs_pkg::slot_entry_type     entry,
   input  logic                         en,
   input  logic                         taken,
   input  logic [15:0]                  elapsed,
   input  logic [7:0]                   led,
   input  logic [15:0]                  new_period,
   input  logic [mlfs_pkg::COLOR_W-1:0] color,
   output mlfs_pkg::slot_act_type       act
);

   localparam int CB = mlfs_pkg::CHANNEL_BITS;

   logic toggle;

   // An overshoot counts as reaching zero.
   assign toggle = (elapsed != 16'd0) && (entry.remaining <= elapsed);

   always_comb begin
      act          = '0;
      act.wr_entry = entry;
      act.en_next  = en;
      unique case (op)
         mlfs_pkg::REQ_TICK: begin
            if (en) begin
               act.mem_write = 1'b1;
               if (toggle) begin
                  act.wr_entry.remaining = entry.period;
                  act.wr_entry.lit       = !entry.lit;
                  act.emit               = 1'b1;
                  act.res.write_valid    = 1'b1;
                  act.res.led            = entry.led;
                  if (!entry.lit) begin
                     act.res.brightness = mlfs_pkg::chan_out(entry.color[0*CB +: CB]);
                     act.res.red        = mlfs_pkg::chan_out(entry.color[1*CB +: CB]);
                     act.res.green      = mlfs_pkg::chan_out(entry.color[2*CB +: CB]);
                     act.res.blue       = mlfs_pkg::chan_out(entry.color[3*CB +: CB]);
                  end
               end else begin
                  act.wr_entry.remaining = entry.remaining - elapsed;
               end
            end
         end
         mlfs_pkg::REQ_ENABLE: begin
            if (!en && !taken) begin
               act.mem_write          = 1'b1;
               act.wr_entry.period    = new_period;
               act.wr_entry.remaining = new_period;
               act.wr_entry.lit       = 1'b0;
               act.wr_entry.color     = color;
               act.wr_entry.led       = led;
               act.en_next            = 1'b1;
               act.claim              = 1'b1;
            end
         end
         mlfs_pkg::REQ_DISABLE: begin
            if (en && !taken && (entry.led == led)) begin
               act.en_next = 1'b0;
               act.claim   = 1'b1;
            end
         end
         mlfs_pkg::REQ_DISABLE_ALL: begin
            if (en) begin
               act.en_next         = 1'b0;
               act.emit            = 1'b1;
               act.res.write_valid = 1'b1;
               act.res.led         = entry.led;
            end
         end
         default: begin
            act.en_next = en;
         end
      endcase
   end

endmodule

// ----- rtl/mlfs_rsp_queue.sv -----
// Result path of the flash scheduler: a hold stage that keeps the newest result
// until it is known whether it is the last one, and the output register.
// Uses mlfs_pkg.
module mlfs_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 push,
   input  mlfs_pkg::result_type push_res,
   input  logic                 flush,
   output logic                 can_push,
   output logic                 hold_empty,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output mlfs_pkg::result_type rsp_res,
   output logic                 rsp_commit
);

   logic                              hold_valid_ff, hold_valid_in;
   mlfs_pkg::result_type              hold_res_ff;
   logic [mlfs_pkg::RES_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   mlfs_pkg::result_type              rsp_res_ff;
   logic                              rsp_commit_ff;
   logic                              out_free;
   logic                              full;
   logic                              push_eff;
   logic                              move;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Results past the limit are dropped; the last kept one takes the commit.
   assign full     = !start && (cnt_ff == mlfs_pkg::RES_CNT_W'(mlfs_pkg::MAX_RESULTS));
   assign push_eff = push && !full;
   assign move     = hold_valid_ff && out_free && (push_eff || flush);
   assign can_push = full || !hold_valid_ff || out_free;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (push_eff) begin
         hold_valid_in = 1'b1;
      end else if (move) begin
         hold_valid_in = 1'b0;
      end
      if (start) begin
         cnt_in = push ? mlfs_pkg::RES_CNT_W'(1) : '0;
      end else begin
         cnt_in = cnt_ff + mlfs_pkg::RES_CNT_W'(push_eff);
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_eff) begin
         hold_res_ff <= push_res;
      end
      if (move) begin
         rsp_res_ff    <= hold_res_ff;
         rsp_commit_ff <= flush && !push_eff;
      end
   end

   assign hold_empty = !hold_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res    = rsp_res_ff;
   assign rsp_commit = rsp_commit_ff;

endmodule

// ----- rtl/multi_slot_led_flash_scheduler.sv -----
// Top level of the multi-slot LED flash scheduler.
// Instantiates mlfs_ram, mlfs_slot_alu and mlfs_rsp_queue; uses mlfs_pkg.

// The scheduler keeps a table of SLOT_COUNT flash slots in a synchronous RAM
// and walks the whole table once for every item, one slot per clock while no
// held result stalls the walk: the read port fetches the next slot while the
// update of the previous slot is written back through the write port. The
// block takes no new item until the walk of the current one has ended; an
// item that causes results ends only after its held last result has moved
// into the output register, and a stalled output can hold the walk and that
// final move.
// Tick items age every enabled slot and emit a color write for each slot that
// toggles; enable items claim the first free slot and emit one commit-only
// result; disable items emit an off write for the LED and free its first slot;
// disable-all items emit an off write for every enabled slot and free them all.
// The newest result of an item is held back one step so that the last result of
// the item can carry commit_last. A new item is accepted only once the
// previous item has ended, after its last result has moved into the output
// register, even while that result still waits there. Enabled flags live in
// flip-flops cleared by reset, so no clearing pass is needed; the other slot
// fields are written when a slot is enabled and are only read for enabled slots.
module multi_slot_led_flash_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_elapsed_ticks,
   input  logic [7:0]  req_led_index,
   input  logic [15:0] req_half_period,
   input  logic [7:0]  req_in_brightness,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [7:0]  rsp_out_led,
   output logic [7:0]  rsp_out_brightness,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_commit_last
);

   localparam int IDX_W = mlfs_pkg::SLOT_IDX_W;
   localparam int CNT_W = mlfs_pkg::SLOT_CNT_W;

   // Item state, captured when the item is accepted.
   logic                          busy_ff, busy_in;
   logic [1:0]                    op_ff;
   logic [15:0]                   elapsed_ff;
   logic [7:0]                    led_ff;
   logic [15:0]                   hp_ff;
   logic [mlfs_pkg::COLOR_W-1:0]  color_ff;
   logic                          taken_ff, taken_in;

   // Walk control: the read stage counter and the update stage.
   logic [CNT_W-1:0]              rd_cnt_ff, rd_cnt_in;
   logic                          p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]              p_idx_ff;

   // One enabled flag per slot.
   logic [mlfs_pkg::SLOT_COUNT-1:0] en_ff, en_in;

   logic                          accept;
   logic [1:0]                    op_in;
   mlfs_pkg::result_type          init_res;
   logic                          adv;
   logic                          issue;
   logic                          upd;
   logic                          done_walk;
   logic                          cur_en;

   logic [mlfs_pkg::ENTRY_W-1:0]  ram_rd_data;
   mlfs_pkg::slot_entry_type      slot_rd;
   mlfs_pkg::slot_act_type        act;

   logic                          q_push;
   mlfs_pkg::result_type          q_res;
   logic                          q_can_push;
   logic                          q_hold_empty;
   mlfs_pkg::result_type          rsp_res;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   // An enable with a zero half period behaves as a disable.
   assign op_in = ((req_type == mlfs_pkg::REQ_ENABLE) && (req_half_period == 16'd0))
                  ? mlfs_pkg::REQ_DISABLE : req_type;

   // Enable and disable items produce exactly one result, known at acceptance.
   always_comb begin
      init_res = '0;
      if (op_in == mlfs_pkg::REQ_DISABLE) begin
         init_res.write_valid = 1'b1;
         init_res.led         = req_led_index;
      end
   end

   // The update stage may retire its slot unless it has a result that the
   // result path cannot take yet. While it waits, no new read is issued, so
   // the RAM keeps its read data.
   assign adv       = !p_valid_ff || !act.emit || q_can_push;
   assign issue     = busy_ff && (rd_cnt_ff < CNT_W'(mlfs_pkg::SLOT_COUNT)) && adv;
   assign upd       = p_valid_ff && adv;
   assign done_walk = busy_ff && (rd_cnt_ff == CNT_W'(mlfs_pkg::SLOT_COUNT)) && !p_valid_ff;
   assign cur_en    = en_ff[p_idx_ff];
   assign slot_rd   = mlfs_pkg::slot_entry_type'(ram_rd_data);

   mlfs_ram #(
      .WIDTH (mlfs_pkg::ENTRY_W),
      .DEPTH (mlfs_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (upd && act.mem_write),
      .wr_addr (p_idx_ff),
      .wr_data (act.wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   mlfs_slot_alu u_slot_alu (
      .op         (op_ff),
      .entry      (slot_rd),
      .en         (cur_en),
      .taken      (taken_ff),
      .elapsed    (elapsed_ff),
      .led        (led_ff),
      .new_period (hp_ff),
      .color      (color_ff),
      .act        (act)
   );

   assign q_push = accept ? ((op_in == mlfs_pkg::REQ_ENABLE) || (op_in == mlfs_pkg::REQ_DISABLE))
                          : (upd && act.emit);
   assign q_res  = accept ? init_res : act.res;

   mlfs_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .push       (q_push),
      .push_res   (q_res),
      .flush      (done_walk),
      .can_push   (q_can_push),
      .hold_empty (q_hold_empty),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_res    (rsp_res),
      .rsp_commit (rsp_commit_last)
   );

   assign rsp_write_valid    = rsp_res.write_valid;
   assign rsp_out_led        = rsp_res.led;
   assign rsp_out_brightness = rsp_res.brightness;
   assign rsp_out_red        = rsp_res.red;
   assign rsp_out_green      = rsp_res.green;
   assign rsp_out_blue       = rsp_res.blue;

   always_comb begin
      busy_in    = busy_ff;
      taken_in   = taken_ff;
      rd_cnt_in  = rd_cnt_ff;
      p_valid_in = p_valid_ff;
      en_in      = en_ff;
      if (accept) begin
         busy_in   = 1'b1;
         taken_in  = 1'b0;
         rd_cnt_in = '0;
      end else begin
         if (issue) begin
            rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
            p_valid_in = 1'b1;
         end else if (adv) begin
            p_valid_in = 1'b0;
         end
         if (upd) begin
            en_in[p_idx_ff] = act.en_next;
            taken_in        = taken_ff || act.claim;
         end
         // The item ends once its last result has left the hold stage.
         if (done_walk && q_hold_empty) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         taken_ff   <= 1'b0;
         rd_cnt_ff  <= '0;
         p_valid_ff <= 1'b0;
         en_ff      <= '0;
      end else begin
         busy_ff    <= busy_in;
         taken_ff   <= taken_in;
         rd_cnt_ff  <= rd_cnt_in;
         p_valid_ff <= p_valid_in;
         en_ff      <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_in;
         elapsed_ff <= req_elapsed_ticks;
         led_ff     <= req_led_index;
         hp_ff      <= req_half_period;
         color_ff   <= {mlfs_pkg::chan_in(req_in_blue), mlfs_pkg::chan_in(req_in_green),
                        mlfs_pkg::chan_in(req_in_red), mlfs_pkg::chan_in(req_in_brightness)};
      end
      if (issue) begin
         p_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      end
   end

   // A new item finds the update stage and the hold stage empty.
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!p_valid_ff && q_hold_empty))
      else $error("item accepted while the previous walk is still in flight");

   // The write-back never hits the slot being read in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (upd && act.mem_write && issue) |-> (p_idx_ff != rd_cnt_ff[IDX_W-1:0]))
      else $error("slot RAM read and write at the same address");

   // An item only ends after its last result has left the hold stage.
   a_end_after_flush: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |-> $past(q_hold_empty))
      else $error("item ended with a result still held");

endmodule

// ----- sim/tb_multi_slot_led_flash_scheduler.sv -----
// Self-checking testbench for the multi-slot LED flash scheduler.
// Predicts every LED write and commit from its own copy of the slot table.
// Depends on mlfs_pkg and the multi_slot_led_flash_scheduler RTL.
module tb_multi_slot_led_flash_scheduler;

   // One clock is 20 time units. The whole run is capped at RUN_LIMIT time units,
   // far above the slowest correct run.
   localparam int CLOCK_PERIOD = 20;
   localparam int RUN_LIMIT    = 1_000_000 * CLOCK_PERIOD;
   // WALK_CYCLES covers one walk of the whole table and its pipeline.
   localparam int WALK_CYCLES  = mlfs_pkg::SLOT_COUNT + 4;

   // One request as the sender presents it.
   typedef struct {
      logic [1:0]  op;
      logic [15:0] ticks;
      logic [7:0]  led;
      logic [15:0] period;
      logic [7:0]  bright;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } flash_req_type;

   // The testbench's view of one flash slot. The color is kept packed as
   // brightness, red, green, blue from the top byte down.
   typedef struct {
      logic [15:0] period;
      logic [15:0] left;
      logic        lit;
      logic [31:0] color;
      logic [7:0]  led;
   } flash_slot_type;

   // One expected result: the LED write and its commit flag.
   typedef struct packed {
      mlfs_pkg::result_type body;
      logic                 commit_last;
   } flash_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = mlfs_pkg::REQ_TICK;
   logic [15:0] req_elapsed_ticks = '0;
   logic [7:0]  req_led_index = '0;
   logic [15:0] req_half_period = '0;
   logic [7:0]  req_in_brightness = '0;
   logic [7:0]  req_in_red = '0;
   logic [7:0]  req_in_green = '0;
   logic [7:0]  req_in_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_valid;
   logic [7:0]  rsp_out_led;
   logic [7:0]  rsp_out_brightness;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_commit_last;

   // Predicted slot table and the LED writes still owed by the block.
   flash_slot_type  flash_table [mlfs_pkg::SLOT_COUNT];
   flash_write_type flash_writes [$];

   // When set, neither side inserts idle cycles.
   bit idle_free = 1'b0;

   int error_count = 0;
   int results_checked = 0;
   int requests_by_op [4] = '{default: 0};

   multi_slot_led_flash_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_elapsed_ticks  (req_elapsed_ticks),
      .req_led_index      (req_led_index),
      .req_half_period    (req_half_period),
      .req_in_brightness  (req_in_brightness),
      .req_in_red         (req_in_red),
      .req_in_green       (req_in_green),
      .req_in_blue        (req_in_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_out_led        (rsp_out_led),
      .rsp_out_brightness (rsp_out_brightness),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_commit_last    (rsp_commit_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Builds one LED write. A commit-only result is a write with write_valid
   // low and every other field zero.
   function automatic flash_write_type led_write(input logic wv, input logic [7:0] led,
                                                 input logic [31:0] color);
      flash_write_type w;
      w = '0;
      w.body.write_valid = wv;
      w.body.led         = led;
      w.body.brightness  = color[31:24];
      w.body.red         = color[23:16];
      w.body.green       = color[15:8];
      w.body.blue        = color[7:0];
      return w;
   endfunction

   // Applies one accepted request to the predicted table and queues the LED
   // writes it causes. The last write of the request carries the commit.
   function automatic void predict_flash(input flash_req_type r);
      flash_write_type batch [$];
      bit              done;
      done = 1'b0;
      if (r.op == mlfs_pkg::REQ_TICK) begin
         // A slot whose count is reached or overshot reloads its full half
         // period and toggles; zero elapsed ticks never toggle anything.
         foreach (flash_table[i]) begin
            if (flash_table[i].period == 0) continue;
            if (r.ticks != 0 && flash_table[i].left <= r.ticks) begin
               flash_table[i].left = flash_table[i].period;
               flash_table[i].lit  = !flash_table[i].lit;
               batch.push_back(led_write(1'b1, flash_table[i].led,
                                         flash_table[i].lit ? flash_table[i].color : '0));
            end else begin
               flash_table[i].left = flash_table[i].left - r.ticks;
            end
         end
      end else if (r.op == mlfs_pkg::REQ_ENABLE && r.period != 0) begin
         // First free slot is claimed; with a full table the request is
         // dropped but the commit still goes out.
         foreach (flash_table[i]) begin
            if (!done && flash_table[i].period == 0) begin
               flash_table[i].period = r.period;
               flash_table[i].left   = r.period;
               flash_table[i].lit    = 1'b0;
               flash_table[i].color  = {r.bright, r.red, r.green, r.blue};
               flash_table[i].led    = r.led;
               done = 1'b1;
            end
         end
         batch.push_back(led_write(1'b0, '0, '0));
      end else if (r.op == mlfs_pkg::REQ_DISABLE_ALL) begin
         foreach (flash_table[i]) begin
            if (flash_table[i].period != 0)
               batch.push_back(led_write(1'b1, flash_table[i].led, '0));
            flash_table[i].period = '0;
            flash_table[i].lit    = 1'b0;
         end
      end else begin
         // Disable, or an enable with a zero half period. The off write goes
         // out even when no slot holds the LED; only the first match is freed.
         batch.push_back(led_write(1'b1, r.led, '0));
         foreach (flash_table[i]) begin
            if (!done && flash_table[i].period != 0 && flash_table[i].led == r.led) begin
               flash_table[i].period = '0;
               flash_table[i].left   = '0;
               flash_table[i].lit    = 1'b0;
               done = 1'b1;
            end
         end
      end
      if (batch.size() != 0)
         batch[batch.size() - 1].commit_last = 1'b1;
      flash_writes = {flash_writes, batch};
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got != want)
         report_mismatch(name, got, want);
   endtask

   // Every accepted result is held against the oldest expected write.
   always @(posedge clock) begin : check_results
      flash_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (flash_writes.size() == 0) begin
            report_mismatch("unexpected result for led", rsp_out_led, 8'd0);
         end else begin
            want = flash_writes.pop_front();
            check_field("write_valid", 8'(rsp_write_valid), 8'(want.body.write_valid));
            check_field("out_led", rsp_out_led, want.body.led);
            check_field("out_brightness", rsp_out_brightness, want.body.brightness);
            check_field("out_red", rsp_out_red, want.body.red);
            check_field("out_green", rsp_out_green, want.body.green);
            check_field("out_blue", rsp_out_blue, want.body.blue);
            check_field("commit_last", 8'(rsp_commit_last), 8'(want.commit_last));
         end
      end
   end

   // The result side stalls about a third of the time, except in the
   // stretch where idling is switched off.
   always @(posedge clock) begin
      rsp_stall <= !idle_free && ($urandom_range(99) < 33);
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // The color argument is packed brightness, red, green, blue.
   function automatic flash_req_type build_request(input logic [1:0] op,
                                                   input logic [15:0] ticks,
                                                   input logic [7:0] led,
                                                   input logic [15:0] period,
                                                   input logic [31:0] color);
      flash_req_type r;
      r.op     = op;
      r.ticks  = ticks;
      r.led    = led;
      r.period = period;
      {r.bright, r.red, r.green, r.blue} = color;
      return r;
   endfunction

   // Mostly a handful of LED numbers, so that disables find their slots and
   // duplicates are common.
   function automatic logic [7:0] random_led();
      if ($urandom_range(99) < 70)
         return 8'($urandom_range(15));
      return 8'($urandom);
   endfunction

   // Short half periods keep the slots toggling; a few span the full range.
   function automatic logic [15:0] random_period();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return 16'($urandom_range(8, 1));
      if (pick < 90)
         return 16'($urandom_range(300, 1));
      return 16'($urandom_range(65535, 1));
   endfunction

   function automatic logic [15:0] random_ticks();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5)
         return 16'd0;
      if (pick < 75)
         return 16'($urandom_range(4, 1));
      if (pick < 90)
         return 16'($urandom_range(40, 1));
      return 16'($urandom);
   endfunction

   // LED of a randomly chosen enabled slot, or any LED if none is enabled.
   function automatic logic [7:0] enabled_led();
      logic [7:0] leds [$];
      foreach (flash_table[i])
         if (flash_table[i].period != 0)
            leds.push_back(flash_table[i].led);
      if (leds.size() == 0)
         return random_led();
      return leds[$urandom_range(leds.size() - 1)];
   endfunction

   // Presents one item and returns once it is accepted, with valid left high
   // so that a following item can go out back to back. Idle cycles before the
   // item drop valid for whole clocks.
   task automatic send_request(input flash_req_type r);
      while (!idle_free && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= r.op;
      req_elapsed_ticks <= r.ticks;
      req_led_index     <= r.led;
      req_half_period   <= r.period;
      req_in_brightness <= r.bright;
      req_in_red        <= r.red;
      req_in_green      <= r.green;
      req_in_blue       <= r.blue;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_flash(r);
      requests_by_op[r.op]++;
   endtask

   // Holds the sender off until every predicted write has been seen.
   task automatic wait_for_flash_writes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (flash_writes.size() != 0)
         @(posedge clock);
   endtask

   // Random traffic. Most of it is well-formed bursts: a few enables with
   // random colors, then ticks that make them toggle, sometimes a disable of
   // an LED that is really flashing. The rest is noise of any type.
   task automatic drive_random_traffic(input int count);
      int target;
      target = requests_by_op.sum() + count;
      while (requests_by_op.sum() < target) begin
         if ($urandom_range(99) < 70) begin
            repeat ($urandom_range(4, 1))
               send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), random_led(),
                                          ($urandom_range(99) < 5) ? 16'd0 : random_period(),
                                          $urandom));
            repeat ($urandom_range(6, 2))
               send_request(build_request(mlfs_pkg::REQ_TICK, random_ticks(), 8'($urandom),
                                          16'($urandom), $urandom));
            if ($urandom_range(99) < 50)
               send_request(build_request(mlfs_pkg::REQ_DISABLE, 16'($urandom),
                                          enabled_led(), 16'($urandom), $urandom));
         end else begin
            send_request(build_request(2'($urandom_range(3)), 16'($urandom), 8'($urandom),
                                       16'($urandom), $urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked items: empty table, field extremes, overshoot, zero ticks,
   // enable with a zero half period, duplicate LEDs and missing LEDs.
   task automatic test_directed();
      // Nothing enabled yet: clear-all and tick give no result, a disable of
      // an unknown LED still writes it off and commits.
      send_request(build_request(mlfs_pkg::REQ_DISABLE_ALL, 16'($urandom), 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd1, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE, 16'($urandom), 8'd0,
                                 16'($urandom), $urandom));
      // Slots at both ends of the period and color ranges.
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd0, 16'd1,
                                 32'h0000_0000));
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd255, 16'hFFFF,
                                 32'hFFFF_FFFF));
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd7, 16'd3,
                                 32'h1234_5678));
      // An enable with a zero half period frees LED 7 again.
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd7, 16'd0,
                                 $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd0, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd1, 8'($urandom),
                                 16'($urandom), $urandom));
      // Overshoot on the short slot, then both slots run out at once.
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd9, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'hFFFF, 8'($urandom),
                                 16'($urandom), $urandom));
      // Two slots on the same LED; a disable frees only the first of them.
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd9, 16'd2,
                                 32'hAA55_AA55));
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd9, 16'd5,
                                 32'h55AA_55AA));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd2, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE, 16'($urandom), 8'd9,
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'd3, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE, 16'($urandom), 8'd255,
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE, 16'hFFFF, 8'd0, 16'hFFFF,
                                 32'hFFFF_FFFF));
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd128, 16'hFFFF,
                                 $urandom));
      send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'd3, 16'd1,
                                 $urandom));
      send_request(build_request(mlfs_pkg::REQ_TICK, 16'hFFFE, 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE_ALL, 16'($urandom), 8'($urandom),
                                 16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE_ALL, 16'($urandom), 8'($urandom),
                                 16'($urandom), $urandom));
   endtask

   // Fills every slot, offers one enable too many, and then makes all slots
   // toggle on two ticks and go off in one clear-all: the most results an
   // item can cause.
   task automatic test_table_full();
      send_request(build_request(mlfs_pkg::REQ_DISABLE_ALL, 16'($urandom), 8'($urandom),
                                 16'($urandom), $urandom));
      repeat (mlfs_pkg::SLOT_COUNT + 1)
         send_request(build_request(mlfs_pkg::REQ_ENABLE, 16'($urandom), 8'($urandom),
                                    16'($urandom_range(65535, 1)), $urandom));
      repeat (2)
         send_request(build_request(mlfs_pkg::REQ_TICK, 16'hFFFF, 8'($urandom),
                                    16'($urandom), $urandom));
      send_request(build_request(mlfs_pkg::REQ_DISABLE_ALL, 16'($urandom), 8'($urandom),
                                 16'($urandom), $urandom));
   endtask

   // Random traffic with idling on both sides. Halfway through, the sender
   // holds off until the block has delivered everything it owes.
   task automatic test_random_traffic(input int count);
      drive_random_traffic(count / 2);
      wait_for_flash_writes();
      drive_random_traffic(count - count / 2);
   endtask

   // Random traffic with no idle cycle on either side.
   task automatic test_back_to_back(input int count);
      idle_free = 1'b1;
      drive_random_traffic(count);
      idle_free = 1'b0;
   endtask

   initial begin
      foreach (flash_table[i])
         flash_table[i] = '{period: '0, left: '0, lit: 1'b0, color: '0, led: '0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_random_traffic(220);
      test_back_to_back(100);

      // Drain, then give the block time to show any stray result.
      wait_for_flash_writes();
      repeat (2 * WALK_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d ticks, %0d enables, %0d disables, %0d clear-alls.",
               requests_by_op.sum(), requests_by_op[mlfs_pkg::REQ_TICK],
               requests_by_op[mlfs_pkg::REQ_ENABLE], requests_by_op[mlfs_pkg::REQ_DISABLE],
               requests_by_op[mlfs_pkg::REQ_DISABLE_ALL]);
      $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
      if (error_count == 0)
         $display("tb_multi_slot_led_flash_scheduler passed");
      else
         $display("tb_multi_slot_led_flash_scheduler failed");
      $finish;
   end

   // Watchdog for a block that hangs or loses results.
   initial begin
      #(RUN_LIMIT);
      $display("Timeout with %0d results still expected.", flash_writes.size());
      $display("tb_multi_slot_led_flash_scheduler failed");
      $finish;
   end

endmodule
